[design/cbm_pkg.sv]
// shared types and constants for the cartridge bank mapper
package cbm_pkg;

  localparam int unsigned VisibleLines = 240;
  localparam logic [8:0] VISIBLE_LINES = 9'(VisibleLines);

  localparam int unsigned PaddrW = 4;

  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_PRG   = 3'd1,
    REQ_CHR   = 3'd2,
    REQ_RAM   = 3'd3,
    REQ_TICK  = 3'd4
  } req_kind_e;

  typedef enum logic [2:0] {
    SEL_BANK_SELECT = 3'd0,
    SEL_BANK_DATA   = 3'd1,
    SEL_MIRROR      = 3'd2,
    SEL_RAM_PROTECT = 3'd3,
    SEL_IRQ_LATCH   = 3'd4,
    SEL_IRQ_RELOAD  = 3'd5,
    SEL_IRQ_OFF     = 3'd6,
    SEL_IRQ_ON      = 3'd7
  } reg_sel_e;

  typedef enum logic [2:0] {
    TGT_CHR_LO  = 3'd0,
    TGT_CHR_HI  = 3'd1,
    TGT_CHR_S0  = 3'd2,
    TGT_CHR_S1  = 3'd3,
    TGT_CHR_S2  = 3'd4,
    TGT_CHR_S3  = 3'd5,
    TGT_PRG_A   = 3'd6,
    TGT_PRG_B   = 3'd7
  } bank_tgt_e;

  typedef enum logic [1:0] {
    CFG_ROM_BANKS   = 2'd0,
    CFG_PATTERN_ROM = 2'd1,
    CFG_FOUR_SCREEN = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [8:0] rom_banks_8k;
    logic       pattern_rom_present;
    logic       four_screen;
  } cfg_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic [2:0] slot;
    logic [7:0] ram_byte;
    logic [8:0] scanline;
    logic       display_on;
  } req_t;

  typedef struct packed {
    logic [7:0] bank;
    logic [7:0] read_data;
    logic       irq_out;
    logic       mirroring;
  } rsp_t;

endpackage

[design/cbm_req_if.sv]
// request channel interface
interface cbm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [2:0] reg_select;
  logic [7:0] write_data;
  logic [2:0] slot;
  logic [7:0] ram_byte;
  logic [8:0] scanline;
  logic       display_on;

  modport source (
    output valid, req_type, reg_select, write_data, slot, ram_byte, scanline, display_on,
    input  ready
  );
  modport sink (
    input  valid, req_type, reg_select, write_data, slot, ram_byte, scanline, display_on,
    output ready
  );
endinterface

[design/cbm_rsp_if.sv]
// result channel interface
interface cbm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] bank;
  logic [7:0] read_data;
  logic       irq_out;
  logic       mirroring;

  modport source (
    output valid, bank, read_data, irq_out, mirroring,
    input  ready
  );
  modport sink (
    input  valid, bank, read_data, irq_out, mirroring,
    output ready
  );
endinterface

[design/cbm_cfg.sv]
// apb configuration registers
module cbm_cfg
  import cbm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        CFG_ROM_BANKS:   cfg_d.rom_banks_8k        = pwdata[8:0];
        CFG_PATTERN_ROM: cfg_d.pattern_rom_present = pwdata[0];
        CFG_FOUR_SCREEN: cfg_d.four_screen         = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_ROM_BANKS:   prdata = {23'd0, cfg_q.rom_banks_8k};
      CFG_PATTERN_ROM: prdata = {31'd0, cfg_q.pattern_rom_present};
      CFG_FOUR_SCREEN: prdata = {31'd0, cfg_q.four_screen};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rom_banks_8k        <= 9'd32;
      cfg_q.pattern_rom_present <= 1'b1;
      cfg_q.four_screen         <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/cbm_core.sv]
// mapper state, bank lookup and scanline irq counter
module cbm_core
  import cbm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic step_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  logic [7:0] bank_select_q, bank_select_d;
  logic [7:0] prg_bank_a_q, prg_bank_a_d;
  logic [7:0] prg_bank_b_q, prg_bank_b_d;
  logic [7:0] chr_pair_lo_q, chr_pair_lo_d;
  logic [7:0] chr_pair_hi_q, chr_pair_hi_d;
  logic [7:0] chr_single_q [4];
  logic [7:0] chr_single_d [4];
  logic [7:0] irq_count_q, irq_count_d;
  logic [7:0] irq_reload_q, irq_reload_d;
  logic       irq_enabled_q, irq_enabled_d;
  logic       irq_pending_q, irq_pending_d;
  logic       protect_done_q, protect_done_d;
  logic       mirror_bit_q, mirror_bit_d;

  logic [7:0] second_last;
  logic [7:0] last_bank;
  logic [7:0] prg_bank;
  logic [2:0] chr_win;
  logic [7:0] chr_raw;
  logic [7:0] chr_bank;
  logic       tick_en;
  logic [7:0] count_pre;
  logic [7:0] bank_res;
  logic [7:0] rdata_res;

  // program window lookup
  always_comb begin
    second_last = cfg_i.rom_banks_8k[7:0] - 8'd2;
    last_bank   = cfg_i.rom_banks_8k[7:0] - 8'd1;
    case (req_i.slot[1:0])
      2'd0:    prg_bank = bank_select_q[6] ? second_last : prg_bank_a_q;
      2'd1:    prg_bank = prg_bank_b_q;
      2'd2:    prg_bank = bank_select_q[6] ? prg_bank_a_q : second_last;
      default: prg_bank = last_bank;
    endcase
  end

  // pattern window lookup
  always_comb begin
    chr_win = req_i.slot ^ {bank_select_q[7], 2'b00};
    case (chr_win)
      3'd0:    chr_raw = chr_pair_lo_q;
      3'd1:    chr_raw = chr_pair_lo_q + 8'd1;
      3'd2:    chr_raw = chr_pair_hi_q;
      3'd3:    chr_raw = chr_pair_hi_q + 8'd1;
      default: chr_raw = chr_single_q[chr_win[1:0]];
    endcase
    chr_bank = cfg_i.pattern_rom_present ? chr_raw : (chr_raw & 8'h07);
  end

  always_comb begin
    tick_en   = (req_i.scanline < VISIBLE_LINES) && req_i.display_on &&
                irq_enabled_q && !irq_pending_q;
    count_pre = (req_i.scanline == 9'd0 && irq_count_q != 8'd0) ?
                irq_count_q - 8'd1 : irq_count_q;
  end

  always_comb begin
    bank_select_d  = bank_select_q;
    prg_bank_a_d   = prg_bank_a_q;
    prg_bank_b_d   = prg_bank_b_q;
    chr_pair_lo_d  = chr_pair_lo_q;
    chr_pair_hi_d  = chr_pair_hi_q;
    chr_single_d   = chr_single_q;
    irq_count_d    = irq_count_q;
    irq_reload_d   = irq_reload_q;
    irq_enabled_d  = irq_enabled_q;
    irq_pending_d  = irq_pending_q;
    protect_done_d = protect_done_q;
    mirror_bit_d   = mirror_bit_q;
    bank_res       = 8'd0;
    rdata_res      = 8'd0;
    case (req_i.req_type)
      REQ_WRITE: begin
        if (step_i) begin
          case (req_i.reg_select)
            SEL_BANK_SELECT: begin
              protect_done_d = 1'b1;
              bank_select_d  = req_i.write_data;
            end
            SEL_BANK_DATA: begin
              case (bank_select_q[2:0])
                TGT_CHR_LO: chr_pair_lo_d   = req_i.write_data & 8'hFE;
                TGT_CHR_HI: chr_pair_hi_d   = req_i.write_data & 8'hFE;
                TGT_CHR_S0: chr_single_d[0] = req_i.write_data;
                TGT_CHR_S1: chr_single_d[1] = req_i.write_data;
                TGT_CHR_S2: chr_single_d[2] = req_i.write_data;
                TGT_CHR_S3: chr_single_d[3] = req_i.write_data;
                TGT_PRG_A:  prg_bank_a_d    = req_i.write_data;
                default:    prg_bank_b_d    = req_i.write_data;
              endcase
            end
            SEL_MIRROR: begin
              if (!cfg_i.four_screen) begin
                mirror_bit_d = req_i.write_data[0];
              end
            end
            SEL_IRQ_LATCH: begin
              irq_count_d   = req_i.write_data;
              irq_pending_d = 1'b0;
            end
            SEL_IRQ_RELOAD: begin
              irq_reload_d  = req_i.write_data;
              irq_pending_d = 1'b0;
            end
            SEL_IRQ_OFF: begin
              irq_enabled_d = 1'b0;
              irq_pending_d = 1'b0;
            end
            SEL_IRQ_ON: begin
              irq_enabled_d = 1'b1;
              irq_pending_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      REQ_PRG:  bank_res  = prg_bank;
      REQ_CHR:  bank_res  = chr_bank;
      REQ_RAM:  rdata_res = protect_done_q ? req_i.ram_byte : (req_i.ram_byte ^ 8'h01);
      REQ_TICK: begin
        if (step_i && tick_en) begin
          if (count_pre == 8'd0) begin
            irq_pending_d = 1'b1;
            irq_count_d   = irq_reload_q;
          end else begin
            irq_count_d = count_pre - 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_select_q   <= 8'd0;
      prg_bank_a_q    <= 8'd0;
      prg_bank_b_q    <= 8'd1;
      chr_pair_lo_q   <= 8'd0;
      chr_pair_hi_q   <= 8'd2;
      chr_single_q[0] <= 8'd4;
      chr_single_q[1] <= 8'd5;
      chr_single_q[2] <= 8'd6;
      chr_single_q[3] <= 8'd7;
      irq_count_q     <= 8'd0;
      irq_reload_q    <= 8'd0;
      irq_enabled_q   <= 1'b0;
      irq_pending_q   <= 1'b0;
      protect_done_q  <= 1'b0;
      mirror_bit_q    <= 1'b0;
    end else begin
      bank_select_q  <= bank_select_d;
      prg_bank_a_q   <= prg_bank_a_d;
      prg_bank_b_q   <= prg_bank_b_d;
      chr_pair_lo_q  <= chr_pair_lo_d;
      chr_pair_hi_q  <= chr_pair_hi_d;
      chr_single_q   <= chr_single_d;
      irq_count_q    <= irq_count_d;
      irq_reload_q   <= irq_reload_d;
      irq_enabled_q  <= irq_enabled_d;
      irq_pending_q  <= irq_pending_d;
      protect_done_q <= protect_done_d;
      mirror_bit_q   <= mirror_bit_d;
    end
  end

  assign rsp_o.bank      = bank_res;
  assign rsp_o.read_data = rdata_res;
  assign rsp_o.irq_out   = irq_pending_d;
  assign rsp_o.mirroring = mirror_bit_d;

  // irq only raised by a scanline tick
  a_irq_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_pending_q) |-> $past(step_i) && $past(req_i.req_type) == REQ_TICK)
    else $error("irq raised without tick");

  // mapper state frozen between steps
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(bank_select_q) && $stable(irq_count_q) && $stable(irq_pending_q))
    else $error("state changed without step");

  // protection never returns once lifted
  a_protect_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    protect_done_q |=> protect_done_q)
    else $error("protect flag cleared");

endmodule

[design/cartridge_bank_mapper_scanline_irq.sv]
// top level of the cartridge bank mapper with scanline irq
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_type reg_select write_data slot ram_byte scanline display_on
//   rsp      out  valid/ready    bank read_data irq_out mirroring
//   apb      in   psel/penable   paddr[3:0] pwdata/prdata, pready tied high
//
// one request per cycle unless rsp stalls; stages: input register, result register
// mapper state updates when a request moves from the input to the result register
// reset returns all bank, irq and config registers to their power-on values at once
// a stalled result holds the result register; one more request waits in the input register
module cartridge_bank_mapper_scanline_irq
  import cbm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  cbm_req_if.sink           req,
  cbm_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  req_t in_req;
  req_t s1_q;
  logic s1_valid_q;
  rsp_t core_rsp;
  rsp_t out_q;
  logic out_valid_q;
  logic advance;
  logic step;
  logic in_fire;

  cbm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_req.req_type   = req.req_type;
  assign in_req.reg_select = req.reg_select;
  assign in_req.write_data = req.write_data;
  assign in_req.slot       = req.slot;
  assign in_req.ram_byte   = req.ram_byte;
  assign in_req.scanline   = req.scanline;
  assign in_req.display_on = req.display_on;

  assign advance   = !out_valid_q || rsp.ready;
  assign step      = s1_valid_q && advance;
  assign req.ready = !s1_valid_q || advance;
  assign in_fire   = req.valid && req.ready;

  cbm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .req_i  (s1_q),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_req;
    end
    if (step) begin
      out_q <= core_rsp;
    end
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.bank      = out_q.bank;
  assign rsp.read_data = out_q.read_data;
  assign rsp.irq_out   = out_q.irq_out;
  assign rsp.mirroring = out_q.mirroring;

  // a held request keeps its slot until the result side frees up
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_q))
    else $error("held request lost");

  // an accepted request always lands in the input register
  a_s1_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted request dropped");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp.ready |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");

endmodule
